// ===== design/hex_byte_list_text_decoder_assert.svh =====
// Assertion macros for the hex byte list text decoder.
`ifndef HEX_BYTE_LIST_TEXT_DECODER_ASSERT_SVH
`define HEX_BYTE_LIST_TEXT_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HBL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hbl assertion failed");

// Next-cycle implication, checked outside reset.
`define HBL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hbl assertion failed");

`endif

// ===== design/hbl_pkg.sv =====
// Shared types and constants for the hex byte list text decoder.
`default_nettype none

package hbl_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 16;

    // Largest number of bytes one value may hold.
    localparam logic [COUNT_W-1:0] MAX_BYTES = 16'd65535;
    // Fewest bytes a good value carries.
    localparam logic [COUNT_W-1:0] MIN_BYTES = 16'd2;

    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
    // Offsets that map a letter digit onto 10..15.
    localparam logic [CHAR_W-1:0] LOW_OFS   = 8'd87;
    localparam logic [CHAR_W-1:0] UP_OFS    = 8'd55;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef enum logic [2:0] {
        CK_OTHER  = 3'd0,
        CK_DIGIT  = 3'd1,
        CK_BSLASH = 3'd2,
        CK_CR     = 3'd3,
        CK_LF     = 3'd4,
        CK_SKIP   = 3'd5
    } char_kind_t;

    typedef struct packed {
        char_kind_t kind;
        logic [3:0] digit;
    } char_info_t;

    typedef struct packed {
        logic               emit;
        logic               byte_valid;
        logic [CHAR_W-1:0]  data_byte;
        logic               finished;
        logic               status;
        logic [COUNT_W-1:0] bytes_total;
    } step_result_t;

endpackage

`default_nettype wire

// ===== design/hex_byte_list_text_decoder.sv =====
// Top level of the hex byte list text decoder: input register, step logic, result register.
//
//   channel   dir  beat contents                                         handshake
//   s_        in   text_char, value_start, text_end                      s_valid / s_ready
//   m_        out  byte_valid, data_byte, finished, status, bytes_total  m_valid / m_ready
//
// Each character beat waits in the input register and is decoded there; its result
// beat is loaded into the result register in the cycle after the character advances.
// Throughput, set by the single decode stage, is one character per cycle unless blocked.
// aresetn is synchronous, active low; after reset the decoder idles until a beat
// with value_start. A stalled result register holds only characters that produce
// a result; characters that produce none still advance.
`default_nettype none
`include "hex_byte_list_text_decoder_assert.svh"

module hex_byte_list_text_decoder
    import hbl_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [CHAR_W-1:0]  s_text_char,
    input  wire logic               s_value_start,
    input  wire logic               s_text_end,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_byte_valid,
    output logic [CHAR_W-1:0]       m_data_byte,
    output logic                    m_finished,
    output logic                    m_status,
    output logic [COUNT_W-1:0]      m_bytes_total
);

    // Input register.
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              start_reg;
    logic              end_reg;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic               byte_valid_reg;
    logic [CHAR_W-1:0]  data_byte_reg;
    logic               finished_reg;
    logic               status_reg;
    logic [COUNT_W-1:0] bytes_total_reg;

    char_info_t   info;
    step_result_t result;
    logic         out_free;
    logic         advance;
    logic         load_out;

    hbl_char_class u_class (
        .text_char (char_reg),
        .info      (info)
    );

    hbl_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .info        (info),
        .value_start (start_reg),
        .text_end    (end_reg),
        .result      (result)
    );

    // Result slot is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_ready;
    // Advance the held character unless it needs the slot and the slot is full.
    assign advance  = in_valid_reg && (!result.emit || out_free);
    assign load_out = advance && result.emit;
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture a character beat.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg  <= s_text_char;
            start_reg <= s_value_start;
            end_reg   <= s_text_end;
        end
    end

    // Hold the result beat until taken.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            byte_valid_reg  <= result.byte_valid;
            data_byte_reg   <= result.data_byte;
            finished_reg    <= result.finished;
            status_reg      <= result.status;
            bytes_total_reg <= result.bytes_total;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_byte_valid  = byte_valid_reg;
    assign m_data_byte   = data_byte_reg;
    assign m_finished    = finished_reg;
    assign m_status      = status_reg;
    assign m_bytes_total = bytes_total_reg;

    // A result beat is loaded exactly when the step logic emits and advances.
    `HBL_ASSERT_NEXT(a_load_shows, aclk, aresetn, load_out, m_valid)
    // Every result beat carries a byte, a finish, or both.
    `HBL_ASSERT_NOW(a_beat_has_content, aclk, aresetn, m_valid, m_byte_valid || m_finished)
    // Status is only raised on a finishing beat.
    `HBL_ASSERT_NOW(a_status_on_finish, aclk, aresetn, m_valid && !m_finished, !m_status)
    // A blocked character stays in the input register unchanged.
    `HBL_ASSERT_NEXT(a_held_char, aclk, aresetn, in_valid_reg && !advance,
                     in_valid_reg && $stable(char_reg))

endmodule

`default_nettype wire

// ===== design/hbl_char_class.sv =====
// Character classifier: sorts one text character and extracts its hex digit value.
`default_nettype none

module hbl_char_class
    import hbl_pkg::*;
(
    input  wire logic [CHAR_W-1:0] text_char,
    output char_info_t             info
);

    logic [CHAR_W-1:0] num_diff;
    logic [CHAR_W-1:0] low_diff;
    logic [CHAR_W-1:0] up_diff;

    assign num_diff = text_char - CH_ZERO;
    assign low_diff = text_char - LOW_OFS;
    assign up_diff  = text_char - UP_OFS;

    always_comb begin
        info.kind  = CK_OTHER;
        info.digit = 4'd0;
        if (text_char >= CH_ZERO && text_char <= CH_NINE) begin
            info.kind  = CK_DIGIT;
            info.digit = num_diff[3:0];
        end else if (text_char >= CH_LOW_A && text_char <= CH_LOW_F) begin
            info.kind  = CK_DIGIT;
            info.digit = low_diff[3:0];
        end else if (text_char >= CH_UP_A && text_char <= CH_UP_F) begin
            info.kind  = CK_DIGIT;
            info.digit = up_diff[3:0];
        end else if (text_char == CH_BSLASH) begin
            info.kind = CK_BSLASH;
        end else if (text_char == CH_CR) begin
            info.kind = CK_CR;
        end else if (text_char == CH_LF) begin
            info.kind = CK_LF;
        end else if (text_char == CH_SPACE || text_char == CH_TAB
                     || text_char == CH_COMMA) begin
            info.kind = CK_SKIP;
        end
    end

endmodule

`default_nettype wire

// ===== design/hbl_step.sv =====
// Decoder state registers and the per-character update logic.
`default_nettype none

module hbl_step
    import hbl_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   step_en,
    input  wire char_info_t info,
    input  wire logic   value_start,
    input  wire logic   text_end,
    output step_result_t result
);

    logic               cont_reg, cont_next;
    logic               hpend_reg, hpend_next;
    logic [3:0]         hval_reg, hval_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               lzero_reg, lzero_next;
    logic               pzero_reg, pzero_next;
    logic               done_reg, done_next;

    // State as seen after a start clears it.
    logic               cont_cur;
    logic               hpend_cur;
    logic [3:0]         hval_cur;
    logic [COUNT_W-1:0] count_cur;
    logic               lzero_cur;
    logic               pzero_cur;
    logic               done_cur;

    logic               fin;
    logic               stat;
    logic               got_byte;
    logic [CHAR_W-1:0]  byte_val;
    logic               judge_bad_now;
    logic               judge_bad_next;

    always_comb begin
        cont_cur  = value_start ? 1'b0 : cont_reg;
        hpend_cur = value_start ? 1'b0 : hpend_reg;
        hval_cur  = value_start ? 4'd0 : hval_reg;
        count_cur = value_start ? '0   : count_reg;
        lzero_cur = value_start ? 1'b0 : lzero_reg;
        pzero_cur = value_start ? 1'b0 : pzero_reg;
        done_cur  = value_start ? 1'b0 : done_reg;
    end

    assign judge_bad_now = hpend_cur || (count_cur < MIN_BYTES) || !lzero_cur || !pzero_cur;

    always_comb begin
        cont_next  = cont_cur;
        hpend_next = hpend_cur;
        hval_next  = hval_cur;
        count_next = count_cur;
        lzero_next = lzero_cur;
        pzero_next = pzero_cur;
        fin        = 1'b0;
        stat       = STATUS_GOOD;
        got_byte   = 1'b0;
        byte_val   = '0;
        if (!done_cur) begin
            if (hpend_cur) begin
                if (info.kind != CK_DIGIT) begin
                    fin  = 1'b1;
                    stat = STATUS_BAD;
                end else begin
                    byte_val   = {hval_cur, info.digit};
                    hpend_next = 1'b0;
                    count_next = count_cur + 1'b1;
                    pzero_next = lzero_cur;
                    lzero_next = (byte_val == '0);
                    got_byte   = 1'b1;
                end
            end else begin
                unique case (info.kind)
                    CK_BSLASH: begin
                        cont_next = 1'b1;
                    end
                    CK_CR: begin
                        if (!cont_cur) begin
                            fin  = 1'b1;
                            stat = judge_bad_now;
                        end
                    end
                    CK_LF: begin
                        if (!cont_cur) begin
                            fin  = 1'b1;
                            stat = judge_bad_now;
                        end else begin
                            cont_next = 1'b0;
                        end
                    end
                    CK_SKIP: begin
                        cont_next = cont_cur;
                    end
                    CK_DIGIT: begin
                        if (count_cur >= MAX_BYTES) begin
                            fin  = 1'b1;
                            stat = STATUS_BAD;
                        end else begin
                            hpend_next = 1'b1;
                            hval_next  = info.digit;
                        end
                    end
                    default: begin
                        fin  = 1'b1;
                        stat = STATUS_BAD;
                    end
                endcase
            end
        end
    end

    assign judge_bad_next = hpend_next || (count_next < MIN_BYTES)
                            || !lzero_next || !pzero_next;

    always_comb begin
        result             = '0;
        done_next          = done_cur;
        if (!done_cur) begin
            result.finished = fin || text_end;
            result.status   = fin ? stat : (text_end ? judge_bad_next : STATUS_GOOD);
            if (result.finished) begin
                done_next = 1'b1;
            end
        end
        result.byte_valid  = got_byte;
        result.data_byte   = byte_val;
        result.bytes_total = count_next;
        result.emit        = got_byte || result.finished;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cont_reg  <= 1'b0;
            hpend_reg <= 1'b0;
            hval_reg  <= 4'd0;
            count_reg <= '0;
            lzero_reg <= 1'b0;
            pzero_reg <= 1'b0;
            done_reg  <= 1'b1;
        end else if (step_en) begin
            cont_reg  <= cont_next;
            hpend_reg <= hpend_next;
            hval_reg  <= hval_next;
            count_reg <= count_next;
            lzero_reg <= lzero_next;
            pzero_reg <= pzero_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the hex byte list text decoder, with a scoreboard and drivers.
`default_nettype none

module tb_top;
    import hbl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RANDOM_CHARS_PER_PHASE = 410;

    // One result beat as the decoder presents it on the m_ channel.
    typedef struct packed {
        logic               byte_valid;
        logic [CHAR_W-1:0]  data_byte;
        logic               finished;
        logic               status;
        logic [COUNT_W-1:0] bytes_total;
    } hex_beat_t;

    // Shadow decoder: tracks the value being parsed and queues the result beats it owes.
    class hex_list_model;
        logic               cont_pend;
        logic               hi_pend;
        logic [3:0]         hi_val;
        logic [COUNT_W-1:0] count;
        logic               last_zero;
        logic               prior_zero;
        logic               done;
        hex_beat_t          awaited[$];
        int unsigned        mismatches;

        function new();
            clear();
            done = 1'b1;
            mismatches = 0;
        endfunction

        function void clear();
            cont_pend  = 1'b0;
            hi_pend    = 1'b0;
            hi_val     = '0;
            count      = '0;
            last_zero  = 1'b0;
            prior_zero = 1'b0;
        endfunction

        function int nibble_of(logic [CHAR_W-1:0] ch);
            if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
            if (ch >= CH_LOW_A && ch <= CH_LOW_F) return int'(ch - CH_LOW_A) + 10;
            if (ch >= CH_UP_A && ch <= CH_UP_F) return int'(ch - CH_UP_A) + 10;
            return -1;
        endfunction

        function logic verdict();
            if (hi_pend || count < MIN_BYTES || !last_zero || !prior_zero) return STATUS_BAD;
            return STATUS_GOOD;
        endfunction

        // Advance the shadow state by one accepted character beat.
        function void take_char(logic [CHAR_W-1:0] ch, logic start, logic last);
            hex_beat_t beat;
            int        nib;
            logic      got;
            logic      fin;
            logic      stat;
            logic [CHAR_W-1:0] b;
            got  = 1'b0;
            fin  = 1'b0;
            stat = STATUS_GOOD;
            b    = '0;
            if (start) begin
                clear();
                done = 1'b0;
            end
            if (done) return;
            nib = nibble_of(ch);
            if (hi_pend) begin
                if (nib < 0) begin
                    fin  = 1'b1;
                    stat = STATUS_BAD;
                end else begin
                    b          = {hi_val, nib[3:0]};
                    hi_pend    = 1'b0;
                    count      = count + 1'b1;
                    prior_zero = last_zero;
                    last_zero  = (b == '0);
                    got        = 1'b1;
                end
            end else if (ch == CH_BSLASH) begin
                cont_pend = 1'b1;
            end else if (ch == CH_CR || ch == CH_LF) begin
                if (!cont_pend) begin
                    fin  = 1'b1;
                    stat = verdict();
                end else if (ch == CH_LF) begin
                    cont_pend = 1'b0;
                end
            end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_COMMA) begin
                // separators carry nothing
            end else if (nib < 0 || count >= MAX_BYTES) begin
                fin  = 1'b1;
                stat = STATUS_BAD;
            end else begin
                hi_pend = 1'b1;
                hi_val  = nib[3:0];
            end
            if (!fin && last) begin
                fin  = 1'b1;
                stat = verdict();
            end
            if (fin) done = 1'b1;
            if (!fin && !got) return;
            beat.byte_valid  = got;
            beat.data_byte   = b;
            beat.finished    = fin;
            beat.status      = fin ? stat : STATUS_GOOD;
            beat.bytes_total = count;
            awaited.push_back(beat);
        endfunction

        function void flag(string what, hex_beat_t want, hex_beat_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: want %0b/%02h/%0b/%0b/%0d, got %0b/%02h/%0b/%0b/%0d",
                         what, want.byte_valid, want.data_byte, want.finished, want.status,
                         want.bytes_total, got.byte_valid, got.data_byte, got.finished,
                         got.status, got.bytes_total);
        endfunction

        // Compare one accepted result beat with the oldest one owed.
        function void match_beat(hex_beat_t got);
            hex_beat_t want;
            if (awaited.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.byte_valid !== want.byte_valid || got.data_byte !== want.data_byte ||
                got.finished !== want.finished || got.status !== want.status ||
                got.bytes_total !== want.bytes_total)
                flag("result mismatch", want, got);
        endfunction

        function int open_count();
            return awaited.size();
        endfunction
    endclass

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [CHAR_W-1:0]  s_text_char   = '0;
    logic               s_value_start = 1'b0;
    logic               s_text_end    = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic               m_byte_valid;
    logic [CHAR_W-1:0]  m_data_byte;
    logic               m_finished;
    logic               m_status;
    logic [COUNT_W-1:0] m_bytes_total;

    int unsigned   src_idle_pct   = 0;
    int unsigned   sink_stall_pct = 0;
    logic          sink_hold      = 1'b0;
    event          hold_kick;
    int unsigned   cycle_count    = 0;
    logic [CHAR_W-1:0] text_q[$];

    hex_list_model decoder_model = new();

    hex_byte_list_text_decoder u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_char   (s_text_char),
        .s_value_start (s_value_start),
        .s_text_end    (s_text_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_valid  (m_byte_valid),
        .m_data_byte   (m_data_byte),
        .m_finished    (m_finished),
        .m_status      (m_status),
        .m_bytes_total (m_bytes_total)
    );

    always #5 aclk = ~aclk;

    // Stop a hung run; a correct run ends far below this.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drive ready at the falling edge: random stalls, plus a forced hold-off when asked.
    always @(negedge aclk) begin
        m_ready <= !sink_hold && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Hold the result channel off for a long stretch, counted here so the sender keeps going.
    initial begin
        forever begin
            @(hold_kick);
            @(posedge aclk);
            sink_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            sink_hold = 1'b0;
        end
    end

    // Sample the result channel at the rising edge and check every accepted beat.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            decoder_model.match_beat({m_byte_valid, m_data_byte, m_finished, m_status,
                                      m_bytes_total});
    end

    // Offer one character beat; called and returning at a falling edge. Valid stays
    // high into the next beat unless the sender idles first.
    task automatic send_char(logic [CHAR_W-1:0] ch, logic start, logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_text_char   = ch;
        s_value_start = start;
        s_text_end    = last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        decoder_model.take_char(ch, start, last);
        @(negedge aclk);
    endtask

    // Send the staged text; start flags the first beat, end_at marks the text end (-1 none).
    task automatic play_text(logic start, int end_at);
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], start && i == 0, i == end_at);
    endtask

    // Drop valid and wait until every owed result beat has come back.
    task automatic wait_quiet();
        s_valid = 1'b0;
        while (decoder_model.open_count() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return CH_ZERO + CHAR_W'(nib);
        return (($urandom_range(0, 1) == 1) ? CH_UP_A : CH_LOW_A) + CHAR_W'(nib - 4'd10);
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // Separator between bytes, sometimes with a line continuation.
    function automatic void add_gap();
        case ($urandom_range(0, 11))
            0, 1, 2, 3: add_str(",");
            4: add_str(", ");
            5: add_str(" ");
            6: text_q.push_back(CH_TAB);
            7: ;
            8: begin
                add_str(",\\");
                text_q.push_back(CH_LF);
            end
            9: begin
                add_str(",\\");
                text_q.push_back(CH_CR);
                text_q.push_back(CH_LF);
                add_str("  ");
            end
            10: begin
                add_str("\\");
                text_q.push_back(CH_CR);
                text_q.push_back(CH_LF);
            end
            default: begin
                add_str(", \\ ");
                text_q.push_back(CH_LF);
                text_q.push_back(CH_TAB);
            end
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] noise_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CHAR_W'($urandom_range(0, 255));
            4: return hex_char(4'($urandom_range(0, 15)));
            5: return CH_CR;
            6: return CH_LF;
            7: return CH_BSLASH;
            8: return ($urandom_range(0, 1) == 1) ? CH_COMMA : CH_TAB;
            default: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // Stage a well-formed list of n_bytes; return the text-end index, or -1 for a line end.
    function automatic int build_list(int n_bytes, bit zero_tail);
        logic [CHAR_W-1:0] b;
        int                pick;
        text_q.delete();
        if ($urandom_range(0, 3) == 0) add_str(" ");
        for (int i = 0; i < n_bytes; i++) begin
            b = (zero_tail && i >= n_bytes - 2) ? 8'h00 : CHAR_W'($urandom_range(0, 255));
            text_q.push_back(hex_char(b[7:4]));
            text_q.push_back(hex_char(b[3:0]));
            if (i != n_bytes - 1) add_gap();
        end
        pick = $urandom_range(0, 9);
        if (pick < 6 || text_q.size() == 0) begin
            text_q.push_back(CH_LF);
        end else if (pick < 8) begin
            text_q.push_back(CH_CR);
        end else begin
            return text_q.size() - 1;
        end
        return -1;
    endfunction

    // Break the staged list: insert stray characters, and sometimes cut the tail off.
    function automatic int corrupt(int end_at);
        int drop;
        repeat ($urandom_range(1, 3))
            text_q.insert($urandom_range(0, text_q.size()), noise_char());
        if ($urandom_range(0, 3) == 0) begin
            drop = $urandom_range(0, text_q.size() - 1);
            repeat (drop) void'(text_q.pop_back());
            return text_q.size() - 1;
        end
        return (end_at < 0) ? -1 : text_q.size() - 1;
    endfunction

    initial begin
        int unsigned sent;
        int          n;
        int          end_at;
        int unsigned roll;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: beats before any start are dropped; then a good list across CR LF
        // continuation, a lone digit cut by 0x00, a bad 0xFF, a pending digit at text end,
        // and a bare CR with nothing decoded.
        text_q = '{8'h35, 8'hFF};
        play_text(1'b0, -1);
        text_q.delete();
        add_str("00 fF\\");
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
        add_str("A9,00,00");
        text_q.push_back(CH_LF);
        play_text(1'b1, -1);
        text_q = '{8'h31, 8'h00};
        play_text(1'b1, -1);
        text_q = '{8'hFF};
        play_text(1'b1, -1);
        text_q = '{8'h37};
        play_text(1'b1, 0);
        text_q = '{CH_CR};
        play_text(1'b1, -1);
        wait_quiet();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 83;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 83;
                end
                default: begin
                    src_idle_pct   = 19;
                    sink_stall_pct = 19;
                end
            endcase
            if (phase == 0) begin
                // Stall the result side while a long list streams in, so the input backs up.
                -> hold_kick;
                end_at = build_list(60, 1'b1);
                play_text(1'b1, end_at);
            end
            sent = 0;
            while (sent < RANDOM_CHARS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 8);
                end_at = build_list(n, $urandom_range(0, 3) != 0);
                if (roll >= 70)
                    end_at = corrupt(end_at);
                else if (roll >= 62 && text_q.size() > 1)
                    end_at = $urandom_range(0, text_q.size() - 1);
                sent += text_q.size();
                play_text(1'b1, end_at);
                if ($urandom_range(0, 6) == 0) begin
                    // stray beats with no start between values
                    text_q.delete();
                    repeat ($urandom_range(1, 3)) text_q.push_back(noise_char());
                    play_text(1'b0, -1);
                end
            end
            wait_quiet();
        end

        repeat (8) @(negedge aclk);
        if (decoder_model.mismatches == 0 && decoder_model.open_count() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
